>>> hw/rtl/msp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msp_pkg: shared types and constants of the melody string parser
// Character codes, event kinds, parse phases and the note letter decode.
// ----------------------------------------------------------------------------
package msp_pkg;

	// event kinds
	localparam logic [1:0] KIND_TONE  = 2'd0;
	localparam logic [1:0] KIND_PAUSE = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	// character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SHARP = 8'h23;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_P     = 8'h70;

	localparam int          TB_W       = 10;
	localparam logic [5:0]  OCTAVE     = 6'd12;
	localparam logic [TB_W-1:0] TB_RESET = 10'd20;

	// config register indexes
	localparam logic REG_DEFAULT_TB = 1'b0;

	// parse phases, one-hot
	typedef enum logic [6:0] {
		PH_START       = 7'b0000001,
		PH_TB_FIRST    = 7'b0000010,
		PH_TB_DIG      = 7'b0000100,
		PH_PAUSE_FIRST = 7'b0001000,
		PH_PAUSE_DIG   = 7'b0010000,
		PH_NOTE_MOD    = 7'b0100000,
		PH_NOTE_DIG    = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic       hit;
		logic [5:0] note;
	} letter_t;

	// note letter to base index of the middle octave
	function automatic letter_t note_of_letter(input logic [7:0] c);
		letter_t r;
		r.hit = 1'b1;
		unique case (c)
			8'h63: r.note = 6'd12; // c
			8'h64: r.note = 6'd14; // d
			8'h65: r.note = 6'd16; // e
			8'h66: r.note = 6'd17; // f
			8'h67: r.note = 6'd19; // g
			8'h61: r.note = 6'd21; // a
			8'h62: r.note = 6'd22; // b
			8'h68: r.note = 6'd23; // h
			default: begin
				r.hit  = 1'b0;
				r.note = 6'd0;
			end
		endcase
		return r;
	endfunction

endpackage

>>> hw/rtl/melody_string_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// melody_string_parser: tune text to tone / pause / end / error events
// Parses one character per cycle unless stalled; emits at most one event per character.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake              Payload
// input     in   in_valid / in_stall    character[7:0]
// result    out  out_valid / out_stall  event_kind, note_index, on_time, off_time
// config    in   APB psel/penable       default_timebase at byte address 0
//
// Flow: a request is taken into the input register, then decoded against
// the parse state; its event (if any) is registered into the output register
// as the character leaves. One character per cycle while nothing stalls.
// The longest path is the accumulator times time base multiply feeding the
// x7 / x8 scaling of the event times.
// Stalls: the input register moves on whenever the character gives no event
// or the output register is empty or draining; in_stall rises only while a
// character holding an event waits behind a stalled result.
// Reset clears control state, the parse phase and the time base (to 20).
// ----------------------------------------------------------------------------
module melody_string_parser
	import msp_pkg::*;
#(
	parameter int NOTE_COUNT = 36,
	parameter int NUMBER_MAX = 999
) (
	input  logic        clk,
	input  logic        arst_n,
	// characters
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  character,
	// events
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  event_kind,
	output logic [5:0]  note_index,
	output logic [22:0] on_time,
	output logic [19:0] off_time,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int ACC_W  = $clog2(NUMBER_MAX + 1);
	localparam int PROD_W = ACC_W + TB_W;
	localparam int WIDE_W = (PROD_W + 3 > 23) ? PROD_W + 3 : 23;
	localparam logic [ACC_W-1:0] ACC_MAX  = ACC_W'(NUMBER_MAX);
	localparam logic [6:0]       NOTE_TOP = 7'(NOTE_COUNT - 1);
	localparam logic [1:0]       ADDR_DEFAULT_TB = 2'(4 * REG_DEFAULT_TB);

	// config register
	logic [TB_W-1:0] default_tb_q;

	// input register
	logic       s1_valid_s1;
	logic [7:0] char_s1;

	// parse state
	phase_t          phase_q, phase_d;
	logic [TB_W-1:0] tb_q, tb_d;
	logic [ACC_W-1:0] acc_q, acc_d;
	logic [5:0]      note_q, note_d;

	// output register
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [5:0]  note_out_q;
	logic [22:0] on_q;
	logic [19:0] off_q;

	// decode
	logic        emit;
	logic [1:0]  kind_d;
	logic [5:0]  note_out_d;
	logic [22:0] on_d;
	logic [19:0] off_d;
	logic        advance;

	logic             is_dig;
	logic [3:0]       dig_val;
	logic [ACC_W+3:0] acc_mac;
	logic [ACC_W-1:0] acc_step;
	logic [ACC_W-1:0] acc_first;
	letter_t          letter;
	logic [6:0]       note_up1, note_up12;
	logic [PROD_W-1:0] prod;
	logic [WIDE_W-1:0] prod_w, on_pause_w, on_tone_w;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_DEFAULT_TB) ? 32'(default_tb_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_tb_q <= TB_RESET;
		end else if (psel && penable && pwrite && pready) begin
			// single register: every address decodes to it
			default_tb_q <= pwdata[TB_W-1:0];
		end
	end

	// ---------------- input register ----------------
	assign advance  = s1_valid_s1 && (!emit || !out_valid_q || !out_stall);
	assign in_stall = s1_valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			s1_valid_s1 <= 1'b1;
		end else if (advance) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= character;
		end
	end

	// ---------------- datapath ----------------
	assign is_dig    = (char_s1 >= CH_0) && (char_s1 <= CH_9);
	assign dig_val   = 4'(char_s1 - CH_0);
	assign acc_mac   = (ACC_W+4)'(acc_q) * (ACC_W+4)'(10) + (ACC_W+4)'(dig_val);
	assign acc_step  = (acc_mac > (ACC_W+4)'(ACC_MAX)) ? ACC_MAX : acc_mac[ACC_W-1:0];
	assign acc_first = ACC_W'(dig_val);
	assign letter    = note_of_letter(char_s1);
	assign note_up1  = 7'(note_q) + 7'd1;
	assign note_up12 = 7'(note_q) + 7'(OCTAVE);

	// n * time_base, then x8 for pauses and x7 for tones
	assign prod       = PROD_W'(acc_q) * PROD_W'(tb_q);
	assign prod_w     = WIDE_W'(prod);
	assign on_pause_w = prod_w << 3;
	assign on_tone_w  = on_pause_w - prod_w;

	always_comb begin
		phase_d    = phase_q;
		tb_d       = tb_q;
		acc_d      = acc_q;
		note_d     = note_q;
		emit       = 1'b0;
		kind_d     = KIND_ERROR;
		note_out_d = 6'd0;
		on_d       = 23'd0;
		off_d      = 20'd0;

		if (char_s1 == CH_NUL) begin
			phase_d = PH_START;
			acc_d   = '0;
			tb_d    = default_tb_q;
			emit    = 1'b1;
			kind_d  = KIND_END;
		end else begin
			unique case (phase_q)
				PH_START: begin
					if (char_s1 == CH_T) begin
						phase_d = PH_TB_FIRST;
						acc_d   = '0;
					end else if (char_s1 == CH_P) begin
						phase_d = PH_PAUSE_FIRST;
						acc_d   = '0;
					end else if (char_s1 == CH_COMMA) begin
						// lone comma is dropped
					end else if (letter.hit) begin
						note_d  = letter.note;
						acc_d   = '0;
						phase_d = PH_NOTE_MOD;
					end else begin
						emit = 1'b1;
					end
				end
				PH_TB_FIRST, PH_PAUSE_FIRST: begin
					if (is_dig) begin
						acc_d   = acc_first;
						phase_d = (phase_q == PH_TB_FIRST) ? PH_TB_DIG : PH_PAUSE_DIG;
					end else begin
						emit = 1'b1;
					end
				end
				PH_TB_DIG: begin
					if (is_dig) begin
						acc_d = acc_step;
					end else if (char_s1 == CH_COMMA) begin
						tb_d    = TB_W'(acc_q);
						acc_d   = '0;
						phase_d = PH_START;
					end else begin
						emit = 1'b1;
					end
				end
				PH_PAUSE_DIG: begin
					if (is_dig) begin
						acc_d = acc_step;
					end else begin
						// terminator is any non-digit other than NUL and is consumed
						acc_d   = '0;
						phase_d = PH_START;
						emit    = 1'b1;
						kind_d  = KIND_PAUSE;
						on_d    = on_pause_w[22:0];
					end
				end
				PH_NOTE_MOD: begin
					if (is_dig) begin
						acc_d   = acc_first;
						phase_d = PH_NOTE_DIG;
					end else if (char_s1 == CH_MINUS) begin
						note_d = (note_q != 6'd0) ? note_q - 6'd1 : 6'd0;
					end else if (char_s1 == CH_LT) begin
						note_d = (note_q > OCTAVE) ? note_q - OCTAVE : 6'd0;
					end else if (char_s1 == CH_SHARP) begin
						note_d = (note_up1 > NOTE_TOP) ? NOTE_TOP[5:0] : note_up1[5:0];
					end else if (char_s1 == CH_GT) begin
						note_d = (note_up12 > NOTE_TOP) ? NOTE_TOP[5:0] : note_up12[5:0];
					end else begin
						emit = 1'b1;
					end
				end
				PH_NOTE_DIG: begin
					if (is_dig) begin
						acc_d = acc_step;
					end else if (char_s1 == CH_COMMA) begin
						acc_d      = '0;
						phase_d    = PH_START;
						emit       = 1'b1;
						kind_d     = KIND_TONE;
						note_out_d = note_q;
						on_d       = on_tone_w[22:0];
						off_d      = prod_w[19:0];
					end else begin
						emit = 1'b1;
					end
				end
				default: begin
					emit = 1'b1;
				end
			endcase

			// errors drop the command
			if (emit && kind_d == KIND_ERROR) begin
				phase_d = PH_START;
				acc_d   = '0;
			end
		end
	end

	// ---------------- parse state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			tb_q    <= TB_RESET;
			acc_q   <= '0;
			note_q  <= 6'd0;
		end else if (advance) begin
			phase_q <= phase_d;
			tb_q    <= tb_d;
			acc_q   <= acc_d;
			note_q  <= note_d;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			kind_q     <= kind_d;
			note_out_q <= note_out_d;
			on_q       <= on_d;
			off_q      <= off_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_kind = kind_q;
	assign note_index = note_out_q;
	assign on_time    = on_q;
	assign off_time   = off_q;

`ifndef SYNTHESIS
	a_err_returns_start: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit && kind_d == KIND_ERROR |=> phase_q == PH_START && acc_q == '0)
		else $error("error event did not return parser to start");

	a_end_reloads_tb: assert property (@(posedge clk) disable iff (!arst_n)
		advance && char_s1 == CH_NUL |=> tb_q == $past(default_tb_q) && phase_q == PH_START)
		else $error("end of tune did not reload time base");

	a_note_range: assert property (@(posedge clk) disable iff (!arst_n)
		7'(note_q) <= NOTE_TOP)
		else $error("note index beyond table");

	a_acc_sat: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q <= ACC_MAX)
		else $error("number accumulator above saturation limit");

	a_nontone_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q != KIND_TONE |-> note_out_q == 6'd0 && off_q == 20'd0)
		else $error("non-tone event carries tone fields");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the melody string parser
// Feeds tune text through the valid/stall request channel and compares every
// event against an in-bench parser that tracks phase, time base, number and
// note. A short scripted opening is followed by random command streams run
// under several idle/stall mixes, with the default time base rewritten
// between mixes while the block is quiet.
// ----------------------------------------------------------------------------
module tb_top;
	import msp_pkg::*;

	localparam int NUM_MAX     = 999;        // number field saturation
	localparam int NOTE_TOP    = 35;         // highest note index
	localparam int LONG_HOLD   = 400;        // long receiver hold-off, cycles
	localparam int SETTLE      = 8;          // quiet cycles waited after the last owed event
	localparam int REPORT_MAX  = 10;         // mismatches printed in full
	localparam int BATCH_CHARS = 190;        // least random characters per stall mix; mix 1 gets 60 more
	localparam int TIMEOUT_NS  = 20_000_000; // hang guard limit in ns

	typedef struct packed {
		logic [1:0]  kind;
		logic [5:0]  note;
		logic [22:0] on_ms;
		logic [19:0] off_ms;
	} tune_event_t;

	// one scripted character, with its event typed in where it is obvious
	typedef struct packed {
		logic [7:0]  ch;
		logic        typed;
		tune_event_t ev;
	} script_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [7:0]  character = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  event_kind;
	logic [5:0]  note_index;
	logic [22:0] on_time;
	logic [19:0] off_time;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [1:0]  paddr     = 2'd0;
	logic [31:0] pwdata    = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	melody_string_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.character (character),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.event_kind(event_kind),
		.note_index(note_index),
		.on_time   (on_time),
		.off_time  (off_time),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Parser mirror. default_tb shadows the register; tune_tb only picks
	// it up at NUL (and reset), just like the block.
	// ------------------------------------------------------------------
	phase_t      tune_phase = PH_START;
	logic [9:0]  tune_tb    = TB_RESET;
	logic [9:0]  tune_acc   = '0;
	logic [5:0]  tune_note  = '0;
	logic [9:0]  default_tb = TB_RESET;

	tune_event_t pending_events [$];  // events still owed by the block
	logic [7:0]  tune_text [$];       // random characters waiting to go out
	int unsigned fault_count = 0;

	int          send_idle_pct = 0;   // sender idles this % of cycles
	int          stall_pct     = 0;   // receiver stalls this % of cycles
	logic        hold_on       = 1'b0;
	event        hold_trig;

	logic [7:0]  note_letters [8] = '{"c", "d", "e", "f", "g", "a", "b", "h"};
	logic [7:0]  note_mods [4]    = '{CH_MINUS, CH_SHARP, CH_LT, CH_GT};

	function automatic bit is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	// decimal accumulate with saturation
	function automatic logic [9:0] add_digit(input logic [9:0] acc, input logic [7:0] c);
		int unsigned v;
		v = acc * 10 + (c - CH_0);
		return (v > NUM_MAX) ? 10'(NUM_MAX) : 10'(v);
	endfunction

	// letter to middle octave index, -1 when the byte is no note letter
	function automatic int letter_note(input logic [7:0] c);
		case (c)
			"c": return 12;
			"d": return 14;
			"e": return 16;
			"f": return 17;
			"g": return 19;
			"a": return 21;
			"b": return 22;
			"h": return 23;
			default: return -1;
		endcase
	endfunction

	// advance the mirror by one accepted character
	task automatic parse_char(input logic [7:0] c, output bit emits, output tune_event_t ev);
		int unsigned n;
		int unsigned tb;
		int unsigned v;
		int          ln;
		bit          bad;
		emits = 1'b0;
		bad   = 1'b0;
		ev    = '0;
		n     = tune_acc;
		tb    = tune_tb;
		ln    = letter_note(c);
		if (c == CH_NUL) begin
			// NUL in any phase: drop the partial command, reload time base
			tune_phase = PH_START;
			tune_acc   = '0;
			tune_tb    = default_tb;
			emits      = 1'b1;
			ev.kind    = KIND_END;
		end else begin
			case (tune_phase)
				PH_START: begin
					if (c == CH_T) begin
						tune_phase = PH_TB_FIRST;
						tune_acc   = '0;
					end else if (c == CH_P) begin
						tune_phase = PH_PAUSE_FIRST;
						tune_acc   = '0;
					end else if (c == CH_COMMA) begin
						// lone comma, nothing happens
					end else if (ln < 0) begin
						bad = 1'b1;
					end else begin
						tune_note  = 6'(ln);
						tune_acc   = '0;
						tune_phase = PH_NOTE_MOD;
					end
				end
				PH_TB_FIRST, PH_PAUSE_FIRST: begin
					if (!is_digit(c)) begin
						bad = 1'b1;
					end else begin
						tune_acc   = add_digit('0, c);
						tune_phase = (tune_phase == PH_TB_FIRST) ? PH_TB_DIG : PH_PAUSE_DIG;
					end
				end
				PH_TB_DIG: begin
					if (is_digit(c)) begin
						tune_acc = add_digit(tune_acc, c);
					end else if (c != CH_COMMA) begin
						bad = 1'b1;
					end else begin
						tune_tb    = tune_acc;
						tune_acc   = '0;
						tune_phase = PH_START;
					end
				end
				PH_PAUSE_DIG: begin
					if (is_digit(c)) begin
						tune_acc = add_digit(tune_acc, c);
					end else begin
						// any terminator closes the pause and is eaten
						tune_acc   = '0;
						tune_phase = PH_START;
						emits      = 1'b1;
						ev.kind    = KIND_PAUSE;
						ev.on_ms   = 23'(8 * n * tb);
					end
				end
				PH_NOTE_MOD: begin
					if (is_digit(c)) begin
						tune_acc   = add_digit('0, c);
						tune_phase = PH_NOTE_DIG;
					end else if (c == CH_MINUS) begin
						tune_note = (tune_note > 0) ? tune_note - 6'd1 : 6'd0;
					end else if (c == CH_LT) begin
						tune_note = (tune_note > OCTAVE) ? tune_note - OCTAVE : 6'd0;
					end else if (c == CH_SHARP || c == CH_GT) begin
						v = tune_note + ((c == CH_SHARP) ? 1 : OCTAVE);
						tune_note = (v > NOTE_TOP) ? 6'(NOTE_TOP) : 6'(v);
					end else begin
						bad = 1'b1;
					end
				end
				PH_NOTE_DIG: begin
					if (is_digit(c)) begin
						tune_acc = add_digit(tune_acc, c);
					end else if (c != CH_COMMA) begin
						bad = 1'b1;
					end else begin
						tune_acc   = '0;
						tune_phase = PH_START;
						emits      = 1'b1;
						ev.kind    = KIND_TONE;
						ev.note    = tune_note;
						ev.on_ms   = 23'(7 * n * tb);
						ev.off_ms  = 20'(n * tb);
					end
				end
				default: bad = 1'b1;
			endcase
		end
		if (bad) begin
			tune_phase = PH_START;
			tune_acc   = '0;
			emits      = 1'b1;
			ev         = '0;
			ev.kind    = KIND_ERROR;
		end
	endtask

	// ------------------------------------------------------------------
	// Request side. Random idle gaps go in front of each character; once
	// offered, the character stays put until the edge that takes it.
	// ------------------------------------------------------------------
	task automatic offer_char(input logic [7:0] c, input bit typed, input tune_event_t typed_ev);
		bit          emits;
		tune_event_t ev;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		character <= c;
		do @(posedge clk); while (in_stall);
		// taken at this edge
		parse_char(c, emits, ev);
		if (typed)
			pending_events.push_back(typed_ev);
		else if (emits)
			pending_events.push_back(ev);
	endtask

	// ------------------------------------------------------------------
	// Result side: random stalls, plus a long hold when triggered.
	// ------------------------------------------------------------------
	always @(posedge clk)
		out_stall <= hold_on || ($urandom_range(99) < stall_pct);

	always begin
		@(hold_trig);
		hold_on <= 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		hold_on <= 1'b0;
	end

	// compare each taken event with the oldest one owed
	always @(posedge clk) begin
		tune_event_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_events.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_MAX)
					$display("unexpected event: kind %0d note %0d on %0d off %0d",
						event_kind, note_index, on_time, off_time);
			end else begin
				want = pending_events.pop_front();
				if (event_kind !== want.kind || note_index !== want.note ||
						on_time !== want.on_ms || off_time !== want.off_ms) begin
					fault_count++;
					if (fault_count <= REPORT_MAX)
						$display("mismatch: want kind %0d note %0d on %0d off %0d, got kind %0d note %0d on %0d off %0d",
							want.kind, want.note, want.on_ms, want.off_ms,
							event_kind, note_index, on_time, off_time);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Config: APB setup + access, written at the edge with pready high.
	// ------------------------------------------------------------------
	task automatic set_default_tb(input logic [9:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 2'(4 * REG_DEFAULT_TB);
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		default_tb = value;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// wait for every owed event, then let in-flight silent characters clear
	task automatic quiesce();
		while (pending_events.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Random text: mostly well-formed commands with random content, the
	// rest noise bytes and commands cut short by a random byte.
	// ------------------------------------------------------------------
	function automatic logic [7:0] rand_digit();
		return CH_0 + 8'($urandom_range(9));
	endfunction

	function automatic logic [7:0] rand_letter();
		return note_letters[$urandom_range(7)];
	endfunction

	function automatic logic [7:0] rand_mod();
		return note_mods[$urandom_range(3)];
	endfunction

	// any byte that ends a pause: non-digit, non-NUL
	function automatic logic [7:0] rand_terminator();
		logic [7:0] b;
		if ($urandom_range(1))
			return CH_COMMA;
		do b = 8'($urandom_range(255, 1)); while (is_digit(b));
		return b;
	endfunction

	// mostly short numbers; a few long ones to hit saturation
	task automatic add_number();
		int pick;
		int len;
		pick = $urandom_range(99);
		len  = (pick < 70) ? $urandom_range(2, 1) : (pick < 90) ? 3 : $urandom_range(5, 4);
		repeat (len) tune_text.push_back(rand_digit());
	endtask

	task automatic add_command();
		int pick;
		pick = $urandom_range(99);
		if (pick < 40) begin
			// tone
			tune_text.push_back(rand_letter());
			repeat ($urandom_range(3)) tune_text.push_back(rand_mod());
			add_number();
			tune_text.push_back(CH_COMMA);
		end else if (pick < 55) begin
			tune_text.push_back(CH_P);
			add_number();
			tune_text.push_back(rand_terminator());
		end else if (pick < 65) begin
			tune_text.push_back(CH_T);
			add_number();
			tune_text.push_back(CH_COMMA);
		end else if (pick < 70) begin
			tune_text.push_back(CH_NUL);
		end else if (pick < 74) begin
			tune_text.push_back(CH_COMMA);
		end else if (pick < 88) begin
			tune_text.push_back(8'($urandom_range(255)));
		end else begin
			// broken command
			case ($urandom_range(2))
				0: begin
					tune_text.push_back(rand_letter());
					if ($urandom_range(1)) tune_text.push_back(rand_mod());
					if ($urandom_range(1)) add_number();
				end
				1: begin
					tune_text.push_back(CH_T);
					if ($urandom_range(1)) add_number();
				end
				default: tune_text.push_back(CH_P);
			endcase
			tune_text.push_back(8'($urandom_range(255)));
		end
	endtask

	task automatic run_batch(input int count);
		int sent;
		sent = 0;
		while (sent < count) begin
			add_command();
			while (tune_text.size() != 0) begin
				offer_char(tune_text.pop_front(), 1'b0, '0);
				sent++;
			end
		end
		in_valid <= 1'b0;
	endtask

	// scripted row builders
	function automatic script_row_t plain(input logic [7:0] c);
		script_row_t r;
		r    = '0;
		r.ch = c;
		return r;
	endfunction

	function automatic script_row_t owed(input logic [7:0] c, input logic [1:0] kind,
			input logic [5:0] note, input logic [22:0] on_ms, input logic [19:0] off_ms);
		script_row_t r;
		r           = '0;
		r.ch        = c;
		r.typed     = 1'b1;
		r.ev.kind   = kind;
		r.ev.note   = note;
		r.ev.on_ms  = on_ms;
		r.ev.off_ms = off_ms;
		return r;
	endfunction

	script_row_t script [$];

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		// time base is 20 out of reset
		script = '{
			plain(CH_COMMA),                                   // lone comma
			owed(8'hFF, KIND_ERROR, 6'd0, 23'd0, 20'd0),       // unknown command
			plain("c"), plain(CH_LT), plain(CH_MINUS),         // pinned at 0
			plain("9"), plain("9"), plain("9"), plain("9"),    // saturates at 999
			owed(CH_COMMA, KIND_TONE, 6'd0, 23'd139860, 20'd19980),
			plain("h"), plain(CH_GT), plain(CH_SHARP),         // pinned at top
			plain("1"),
			owed(CH_COMMA, KIND_TONE, 6'd35, 23'd140, 20'd20),
			plain(CH_T), plain(CH_0), plain(CH_COMMA),         // zero time base
			plain(CH_P), plain("7"),
			owed(";", KIND_PAUSE, 6'd0, 23'd0, 20'd0),
			plain("g"),                                        // NUL cuts a note
			owed(CH_NUL, KIND_END, 6'd0, 23'd0, 20'd0),
			plain(CH_P),                                       // letter for digit
			owed("a", KIND_ERROR, 6'd0, 23'd0, 20'd0)
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			offer_char(script[i].ch, script[i].typed, script[i].ev);
		in_valid <= 1'b0;
		quiesce();

		// mix 1: top time base, no idling, one long receiver hold-off
		set_default_tb(10'(NUM_MAX));
		-> hold_trig;
		run_batch(BATCH_CHARS + 60);
		quiesce();

		// mix 2: bottom time base, sender idles
		set_default_tb(10'd1);
		send_idle_pct = 64;
		run_batch(BATCH_CHARS);
		quiesce();

		// mix 3: random time base, receiver stalls
		set_default_tb(10'($urandom_range(NUM_MAX, 1)));
		send_idle_pct = 0;
		stall_pct    <= 64;
		run_batch(BATCH_CHARS);
		quiesce();

		// mix 4: back to the reset value, both sides idle lightly
		set_default_tb(TB_RESET);
		send_idle_pct = 15;
		stall_pct    <= 15;
		run_batch(BATCH_CHARS);

		quiesce();
		if (fault_count == 0)
			$display("[melody_string_parser] OK");
		else
			$display("[melody_string_parser] ERROR");
		$finish;
	end

	// hang guard
	initial begin
		#(TIMEOUT_NS);
		$display("[melody_string_parser] ERROR");
		$finish;
	end

endmodule
